/* rtl/dsrt_pkg.sv */
package dsrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int KEY_W       = YEAR_W + MONTH_W + DAY_W;
    localparam int AMT_W       = 32;
    localparam int POS_W       = 4;
    localparam int ENTRY_W     = 5;
    localparam int STATUS_W    = 3;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_BAD_DATE  = 3'd3,
        STS_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // key packs year, month, day so that binary order matches date order
    typedef struct packed {
        logic        [KEY_W-1:0] key;
        logic signed [AMT_W-1:0] amt;
    } t_rec;

    typedef struct packed {
        logic ins;
        logic del;
        t_rec rec;
    } t_cell_ctrl;

endpackage

/* rtl/date_sorted_record_table.sv */
// Channel | Handshake                 | Word
// --------+---------------------------+---------------------------------------------
// in      | i_in_valid / o_in_ready   | operation, year, month, day, amount, position
// out     | o_out_valid / i_out_ready | status, entry_count, out_year/month/day/amount
//
// Each word is latched first; then, in the execute state, the cell row compares
// all keys in parallel and shifts by one place for insert or delete.
// The result sits in an output register; the next word is taken while it waits.
// A stalled output holds the operation in its execute cycle until the register frees.
// Synchronous active-low reset empties the table (count 0); cell contents are not cleared.
module date_sorted_record_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic [dsrt_pkg::YEAR_W-1:0]         i_year,
    input  logic [dsrt_pkg::MONTH_W-1:0]        i_month,
    input  logic [dsrt_pkg::DAY_W-1:0]          i_day,
    input  logic signed [dsrt_pkg::AMT_W-1:0]   i_amount_cents,
    input  logic [dsrt_pkg::POS_W-1:0]          i_position,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dsrt_pkg::STATUS_W-1:0]       o_status,
    output logic [dsrt_pkg::ENTRY_W-1:0]        o_entry_count,
    output logic [dsrt_pkg::YEAR_W-1:0]         o_out_year,
    output logic [dsrt_pkg::MONTH_W-1:0]        o_out_month,
    output logic [dsrt_pkg::DAY_W-1:0]          o_out_day,
    output logic signed [dsrt_pkg::AMT_W-1:0]   o_out_amount_cents
);

    dsrt_pkg::t_cell_ctrl                        cell_ctrl;
    dsrt_pkg::t_rec [dsrt_pkg::TABLE_DEPTH-1:0]  recs;
    logic [dsrt_pkg::TABLE_DEPTH-1:0]            lt;
    logic [dsrt_pkg::TABLE_DEPTH-1:0]            match;
    logic [dsrt_pkg::TABLE_DEPTH-1:0]            active;
    logic [dsrt_pkg::CNT_W-1:0]                  count;

    dsrt_ctrl u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_year             (i_year),
        .i_month            (i_month),
        .i_day              (i_day),
        .i_amount_cents     (i_amount_cents),
        .i_position         (i_position),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_entry_count      (o_entry_count),
        .o_out_year         (o_out_year),
        .o_out_month        (o_out_month),
        .o_out_day          (o_out_day),
        .o_out_amount_cents (o_out_amount_cents),
        .i_recs             (recs),
        .i_match            (match),
        .o_cell_ctrl        (cell_ctrl),
        .o_count            (count)
    );

    for (genvar gi = 0; gi < dsrt_pkg::TABLE_DEPTH; gi++) begin : g_cell
        localparam int PREV = (gi == 0) ? 0 : gi - 1;
        localparam int NEXT = (gi == dsrt_pkg::TABLE_DEPTH - 1) ? gi : gi + 1;

        assign active[gi] = (32'(gi) < 32'(count));

        // the head cell sees an always-earlier neighbor, the tail cell refills from itself
        dsrt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_active   (active[gi]),
            .i_prev_lt  ((gi == 0) ? 1'b1 : lt[PREV]),
            .i_prev_rec (recs[PREV]),
            .i_next_rec (recs[NEXT]),
            .o_rec      (recs[gi]),
            .o_lt       (lt[gi]),
            .o_match    (match[gi])
        );
    end

endmodule

/* rtl/dsrt_cell.sv */
module dsrt_cell (
    input  logic                i_clk,
    input  dsrt_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_active,
    input  logic                i_prev_lt,
    input  dsrt_pkg::t_rec      i_prev_rec,
    input  dsrt_pkg::t_rec      i_next_rec,
    output dsrt_pkg::t_rec      o_rec,
    output logic                o_lt,
    output logic                o_match
);

    dsrt_pkg::t_rec r_rec;
    dsrt_pkg::t_rec n_rec;

    // lt marks cells that stay in place: they hold an earlier date
    assign o_lt    = i_active && (i_ctrl.rec.key > r_rec.key);
    assign o_match = i_active && (i_ctrl.rec.key == r_rec.key);
    assign o_rec   = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctrl.ins && !o_lt) begin
            // first cell past the earlier dates takes the new word, the rest shift up
            n_rec = i_prev_lt ? i_ctrl.rec : i_prev_rec;
        end else if (i_ctrl.del && !o_lt) begin
            n_rec = i_next_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

/* rtl/dsrt_ctrl.sv */
module dsrt_ctrl (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_operation,
    input  logic [dsrt_pkg::YEAR_W-1:0]            i_year,
    input  logic [dsrt_pkg::MONTH_W-1:0]           i_month,
    input  logic [dsrt_pkg::DAY_W-1:0]             i_day,
    input  logic signed [dsrt_pkg::AMT_W-1:0]      i_amount_cents,
    input  logic [dsrt_pkg::POS_W-1:0]             i_position,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [dsrt_pkg::STATUS_W-1:0]          o_status,
    output logic [dsrt_pkg::ENTRY_W-1:0]           o_entry_count,
    output logic [dsrt_pkg::YEAR_W-1:0]            o_out_year,
    output logic [dsrt_pkg::MONTH_W-1:0]           o_out_month,
    output logic [dsrt_pkg::DAY_W-1:0]             o_out_day,
    output logic signed [dsrt_pkg::AMT_W-1:0]      o_out_amount_cents,
    input  dsrt_pkg::t_rec [dsrt_pkg::TABLE_DEPTH-1:0] i_recs,
    input  logic [dsrt_pkg::TABLE_DEPTH-1:0]       i_match,
    output dsrt_pkg::t_cell_ctrl                   o_cell_ctrl,
    output logic [dsrt_pkg::CNT_W-1:0]             o_count
);

    dsrt_pkg::t_state                    r_state;
    dsrt_pkg::t_state                    n_state;
    dsrt_pkg::t_op                       r_op;
    dsrt_pkg::t_rec                      r_in_rec;
    logic [dsrt_pkg::POS_W-1:0]          r_pos;
    logic [dsrt_pkg::CNT_W-1:0]          r_count;
    logic [dsrt_pkg::CNT_W-1:0]          n_count;
    logic                                r_out_valid;
    dsrt_pkg::t_status                   r_status;
    dsrt_pkg::t_status                   n_status;
    logic [dsrt_pkg::ENTRY_W-1:0]        r_entry;
    dsrt_pkg::t_rec                      r_out_rec;
    dsrt_pkg::t_rec                      n_out_rec;
    logic                                out_free;
    logic                                do_exec;
    logic                                in_ready;
    logic                                date_good;
    logic                                found;
    dsrt_pkg::t_rec                      rd_rec;

    function automatic logic date_ok(
        input logic [dsrt_pkg::YEAR_W-1:0]  y,
        input logic [dsrt_pkg::MONTH_W-1:0] m,
        input logic [dsrt_pkg::DAY_W-1:0]   d
    );
        logic                        ok;
        logic [dsrt_pkg::DAY_W-1:0]  limit;
        ok    = 1'b1;
        limit = 5'd31;
        case (m) inside
            4'd2:                      limit = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   limit = 5'd30;
            [4'd1:4'd12]:              limit = 5'd31;
            default:                   ok = 1'b0;
        endcase
        return ok && (d <= limit);
    endfunction

    assign out_free  = !r_out_valid || i_out_ready;
    assign date_good = date_ok(r_in_rec.key[dsrt_pkg::KEY_W-1 -: dsrt_pkg::YEAR_W],
                               r_in_rec.key[dsrt_pkg::DAY_W +: dsrt_pkg::MONTH_W],
                               r_in_rec.key[dsrt_pkg::DAY_W-1:0]);
    assign found     = |i_match;
    assign rd_rec    = i_recs[dsrt_pkg::IDX_W'(r_pos)];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            dsrt_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dsrt_pkg::ST_EXEC;
                end
            end
            dsrt_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = dsrt_pkg::ST_IDLE;
                end
            end
            default: n_state = dsrt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        do_exec  = 1'b0;
        case (r_state)
            dsrt_pkg::ST_IDLE: in_ready = 1'b1;
            dsrt_pkg::ST_EXEC: do_exec  = out_free;
            default: begin
                in_ready = 1'b0;
                do_exec  = 1'b0;
            end
        endcase
    end

    // operation result
    always_comb begin
        o_cell_ctrl.ins = 1'b0;
        o_cell_ctrl.del = 1'b0;
        o_cell_ctrl.rec = r_in_rec;
        n_count         = r_count;
        n_status        = dsrt_pkg::STS_OK;
        n_out_rec       = '0;
        case (r_op)
            dsrt_pkg::OP_INSERT: begin
                if (!date_good) begin
                    n_status = dsrt_pkg::STS_BAD_DATE;
                end else if (32'(r_count) >= dsrt_pkg::TABLE_DEPTH) begin
                    n_status = dsrt_pkg::STS_FULL;
                end else begin
                    o_cell_ctrl.ins = do_exec;
                    n_count         = r_count + 1'b1;
                end
            end
            dsrt_pkg::OP_DELETE: begin
                if (!found) begin
                    n_status = dsrt_pkg::STS_NOT_FOUND;
                end else begin
                    o_cell_ctrl.del = do_exec;
                    n_count         = r_count - 1'b1;
                end
            end
            dsrt_pkg::OP_READ: begin
                if (32'(r_pos) >= 32'(r_count)) begin
                    n_status = dsrt_pkg::STS_EMPTY;
                end else begin
                    n_out_rec = rd_rec;
                end
            end
            default: n_status = dsrt_pkg::STS_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsrt_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_op         <= dsrt_pkg::t_op'(i_operation);
            r_in_rec.key <= {i_year, i_month, i_day};
            r_in_rec.amt <= i_amount_cents;
            r_pos        <= i_position;
        end
        if (do_exec) begin
            r_status  <= n_status;
            r_entry   <= dsrt_pkg::ENTRY_W'(n_count);
            r_out_rec <= n_out_rec;
        end
    end

    assign o_in_ready         = in_ready;
    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_entry_count      = r_entry;
    assign o_out_year         = r_out_rec.key[dsrt_pkg::KEY_W-1 -: dsrt_pkg::YEAR_W];
    assign o_out_month        = r_out_rec.key[dsrt_pkg::DAY_W +: dsrt_pkg::MONTH_W];
    assign o_out_day          = r_out_rec.key[dsrt_pkg::DAY_W-1:0];
    assign o_out_amount_cents = r_out_rec.amt;
    assign o_count            = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= dsrt_pkg::TABLE_DEPTH)
        else $error("record count above table depth");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctrl.ins |-> (32'(r_count) < dsrt_pkg::TABLE_DEPTH) && date_good)
        else $error("insert into full table or with bad date");

    a_ins_del_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cell_ctrl.ins && o_cell_ctrl.del))
        else $error("insert and delete at once");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctrl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("count not advanced on insert");

    a_del_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cell_ctrl.del |=> r_count == $past(r_count) - 1'b1)
        else $error("count not dropped on delete");

endmodule
